/* design/fuch_pkg.sv */
// ----------------------------------------------------------------------------
// fuch_pkg: firmware upload command handler package
// Command codes, reply constants and the result word type.
// ----------------------------------------------------------------------------
package fuch_pkg;

    localparam int BUFFER_BYTES_DEF = 65536;

    localparam int WORD_W    = 32;
    localparam int ARG_W     = 24;
    localparam int BYTES_W   = 26;
    localparam int VERSION_W = 24;

    typedef enum logic [7:0] {
        CMD_CLEAR   = 8'h80,
        CMD_DECLARE = 8'h81,
        CMD_STATUS  = 8'h82,
        CMD_SWRESET = 8'h83,
        CMD_PAYLOAD = 8'hAA,
        CMD_CHECK   = 8'hBB,
        CMD_START   = 8'hCC,
        CMD_VERSION = 8'hEE
    } cmd_t;

    localparam logic [WORD_W-1:0] REPLY_OK   = 32'h0000_0001;
    localparam logic [WORD_W-1:0] REPLY_FAIL = 32'hFFFF_FFFF;
    localparam logic [ARG_W-1:0]  COUNT_MAX  = 24'hFF_FFFF;

    typedef struct packed {
        logic [WORD_W-1:0] reply_word;
        logic              reply_valid;
        logic              reset_request;
        logic              upgrade_go;
    } result_t;

endpackage

/* design/fuch_ram.sv */
// ----------------------------------------------------------------------------
// fuch_ram: generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module fuch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/fuch_skid.sv */
// ----------------------------------------------------------------------------
// fuch_skid: result output register with skid stage
// Holds up to two result words so the input side can take one more word after the output stalls.
// ----------------------------------------------------------------------------
module fuch_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  fuch_pkg::result_t push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output fuch_pkg::result_t out_data
);
    import fuch_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    pop;

    assign pop = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop)
        begin
            // skid drains first; push is blocked while skid is full
            out_valid_next  = skid_valid_reg || push;
            out_data_next   = skid_valid_reg ? skid_data_reg : push_data;
            skid_valid_next = 1'b0;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // skid only fills behind a held output word
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word without output word");

    // a held output word with a full skid keeps both
    a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && out_stall |=> skid_valid_reg && out_valid_reg)
        else $error("word lost while stalled");

    // skid drains into the output register on a pop
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && pop |=> !skid_valid_reg && out_valid_reg
            && out_data_reg == $past(skid_data_reg))
        else $error("skid word not forwarded");

endmodule

/* design/firmware_upload_command_handler_core.sv */
// ----------------------------------------------------------------------------
// firmware_upload_command_handler_core: firmware upload command handler
// Decodes serial-link command words, tracks the declared image size and the
// received payload triplets, stores the image bytes, and builds one result
// per command word; a software reset result carries no valid reply.
// ----------------------------------------------------------------------------
// An accepted word's result is registered in the output register, or in the skid word while the output is held.
// Throughput: 1 word per cycle while in_stall is low; the counters and flag update on
//   each accepted word, and each payload word writes its three bytes as one 24-bit row
//   of the image RAM in the same cycle.
// Output side: output register plus one skid word; in_stall rises only when
//   both are full.
// Reset: rst_n clears counters, go flag, version register and handshake
//   state at once; the image store is not cleared (no clearing pass).
// ----------------------------------------------------------------------------
module firmware_upload_command_handler_core #(
    parameter int BUFFER_BYTES = fuch_pkg::BUFFER_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration: firmware_version
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fuch_pkg::VERSION_W-1:0]   cfg_data,
    // command words
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [fuch_pkg::WORD_W-1:0]      spi_word,
    input  logic                             upgrade_ok,
    // results
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [fuch_pkg::WORD_W-1:0]      reply_word,
    output logic                             reply_valid,
    output logic                             reset_request,
    output logic                             upgrade_go
);
    import fuch_pkg::*;

    // image byte a sits in row a div 3, byte a mod 3 of that row
    localparam int LANES = 3;
    localparam int ROWS  = (BUFFER_BYTES + LANES - 1) / LANES;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    // ---------------- state ----------------
    logic [VERSION_W-1:0] firmware_version_reg;
    logic [BYTES_W-1:0]   declared_bytes_reg, declared_bytes_next;
    logic [ARG_W-1:0]     triplet_count_reg, triplet_count_next;
    logic                 go_flag_reg, go_flag_next;

    logic                 accept;
    logic                 buf_full;
    logic [7:0]           cmd;
    logic [ARG_W-1:0]     arg;
    logic [BYTES_W-1:0]   base3;
    logic [BYTES_W-1:0]   arg3;
    logic                 match;
    result_t              result;

    // ---------------- config ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            firmware_version_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            firmware_version_reg <= cfg_data;
        end
    end

    // ---------------- decode ----------------
    assign accept   = in_valid && !in_stall;
    assign in_stall = buf_full;
    assign cmd      = spi_word[WORD_W-1:ARG_W];
    assign arg      = spi_word[ARG_W-1:0];

    // 3*x at 26 bits never wraps for a 24-bit x
    assign base3 = {2'b00, triplet_count_reg} + {1'b0, triplet_count_reg, 1'b0};
    assign arg3  = {2'b00, arg} + {1'b0, arg, 1'b0};
    assign match = (base3 == declared_bytes_reg);

    always_comb
    begin
        declared_bytes_next  = declared_bytes_reg;
        triplet_count_next   = triplet_count_reg;
        go_flag_next         = go_flag_reg;
        result.reply_word    = spi_word;   // echo by default, unknown codes too
        result.reply_valid   = 1'b1;
        result.reset_request = 1'b0;
        case (cmd)
            CMD_CLEAR:
            begin
                declared_bytes_next = '0;
                triplet_count_next  = '0;
                go_flag_next        = 1'b0;
            end
            CMD_DECLARE:
            begin
                declared_bytes_next = arg3;
                triplet_count_next  = '0;
            end
            CMD_STATUS:
            begin
                result.reply_word = upgrade_ok ? REPLY_OK : REPLY_FAIL;
            end
            CMD_SWRESET:
            begin
                result.reply_word    = '0;
                result.reply_valid   = 1'b0;
                result.reset_request = 1'b1;
            end
            CMD_PAYLOAD:
            begin
                // count saturates at all ones
                if (triplet_count_reg != COUNT_MAX)
                begin
                    triplet_count_next = triplet_count_reg + 1'b1;
                end
            end
            CMD_CHECK:
            begin
                result.reply_word = match ? REPLY_OK : REPLY_FAIL;
            end
            CMD_START:
            begin
                go_flag_next = match;
                if (!match)
                begin
                    result.reply_word = REPLY_FAIL;
                end
            end
            CMD_VERSION:
            begin
                result.reply_word = {CMD_VERSION, firmware_version_reg};
            end
            default:
            begin
            end
        endcase
        result.upgrade_go = go_flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            declared_bytes_reg <= '0;
            triplet_count_reg  <= '0;
            go_flag_reg        <= 1'b0;
        end
        else if (accept)
        begin
            declared_bytes_reg <= declared_bytes_next;
            triplet_count_reg  <= triplet_count_next;
            go_flag_reg        <= go_flag_next;
        end
    end

    // ---------------- image store ----------------
    // A payload word lands whole in row triplet_count, low byte first. A row
    // that starts at or past the buffer end is dropped; in the last row the
    // byte slots past the end hold no image byte.
    logic             img_wr_en;
    logic [ROW_W-1:0] row;

    assign row       = triplet_count_reg[ROW_W-1:0];
    assign img_wr_en = accept && (cmd == CMD_PAYLOAD)
        && (base3 < BYTES_W'(BUFFER_BYTES));

    fuch_ram #(
        .WIDTH (ARG_W),
        .DEPTH (ROWS)
    ) u_image_ram (
        .clk     (clk),
        .wr_en   (img_wr_en),
        .wr_addr (row),
        .wr_data (arg),
        .rd_addr (row),
        .rd_data ()
    );

    // ---------------- output ----------------
    result_t out_data;

    fuch_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign reply_word    = out_data.reply_word;
    assign reply_valid   = out_data.reply_valid;
    assign reset_request = out_data.reset_request;
    assign upgrade_go    = out_data.upgrade_go;

    // ---------------- checks ----------------
    // go flag only rises on a start word
    a_go_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(go_flag_reg) |-> $past(accept) && $past(cmd) == CMD_START)
        else $error("go flag set without start command");

    // payload below saturation advances the count by one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd == CMD_PAYLOAD && triplet_count_reg != COUNT_MAX
            |=> triplet_count_reg == $past(triplet_count_reg) + 1'b1)
        else $error("triplet count did not advance");

    // image writes stay inside the buffer rows
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        img_wr_en |-> {{(32-ROW_W){1'b0}}, row} < 32'(ROWS))
        else $error("image write beyond buffer");

    // a software reset result never carries a loaded reply
    a_swreset_reply: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reset_request |-> !reply_valid && reply_word == '0)
        else $error("reset result with reply");

endmodule
